### src/adc_scan_averaging_sequencer_defines.svh
// Assertion macros shared by the converter scan sequencer RTL.
// Depends on nothing; taken in by the files that carry concurrent checks.
`ifndef ADC_SCAN_AVERAGING_SEQUENCER_DEFINES_SVH
`define ADC_SCAN_AVERAGING_SEQUENCER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is held.
`define ADCS_ASSERT_IMPLY(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
    else $error("%m: implication check failed");
// Next-cycle implication, disabled while reset is held.
`define ADCS_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
    else $error("%m: next-cycle check failed");
`else
`define ADCS_ASSERT_IMPLY(label, clk, rst_n, lhs, rhs)
`define ADCS_ASSERT_NEXT(label, clk, rst_n, lhs, rhs)
`endif

`endif

### src/adcs_pkg.sv
// Widths, codes and defaults for the converter scan sequencer.
// Depends on nothing; used by the channel interfaces and the top level.
package adcs_pkg;

  localparam int unsigned OP_W        = 2;
  localparam int unsigned SAMPLE_W    = 10;
  localparam int unsigned CH_W        = 3;
  localparam int unsigned MASK_W      = 8;
  localparam int unsigned SUM_W       = 16;
  localparam int unsigned COUNT_W     = 7;
  localparam int unsigned RDATA_W     = 16;
  localparam int unsigned TABLE_DEPTH = 8;
  localparam int unsigned DIV_M_W     = SUM_W + 1;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;

  localparam int unsigned DEF_SAMPLES_TO_AVERAGE = 16;
  localparam int unsigned DEF_CHANNELS           = 8;

  localparam logic [RDATA_W-1:0] NO_RESULT = 16'hFFFF;

  localparam logic [OP_W-1:0] OP_SAMPLE = 2'd0;
  localparam logic [OP_W-1:0] OP_START  = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLED_MASK = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FREE_RUN     = 1'd1;

endpackage

### src/adcs_in_if.sv
// Input channel: valid/ready handshake carrying one request item.
// Depends on adcs_pkg for the field widths.
interface adcs_in_if;
  logic                          valid;
  logic                          ready;
  logic [adcs_pkg::OP_W-1:0]     operation;
  logic [adcs_pkg::SAMPLE_W-1:0] sample_value;
  logic [adcs_pkg::CH_W-1:0]     read_channel;

  modport source (output valid, output operation, output sample_value,
                  output read_channel, input ready);
  modport sink   (input valid, input operation, input sample_value,
                  input read_channel, output ready);
endinterface

### src/adcs_out_if.sv
// Result channel: valid/ready handshake carrying one result item.
// Depends on adcs_pkg for the field widths.
interface adcs_out_if;
  logic                          valid;
  logic                          ready;
  logic                          start_conversion;
  logic [adcs_pkg::CH_W-1:0]     conv_channel;
  logic                          avg_valid;
  logic [adcs_pkg::CH_W-1:0]     avg_channel;
  logic [adcs_pkg::SAMPLE_W-1:0] avg_value;
  logic [adcs_pkg::RDATA_W-1:0]  read_data;

  modport source (output valid, output start_conversion, output conv_channel,
                  output avg_valid, output avg_channel, output avg_value,
                  output read_data, input ready);
  modport sink   (input valid, input start_conversion, input conv_channel,
                  input avg_valid, input avg_channel, input avg_value,
                  input read_data, output ready);
endinterface

### src/adc_scan_averaging_sequencer.sv
// Round-robin converter scan sequencer with per-channel averaging.
// Each accepted item's result is registered in the output register.
// Throughput: one item per cycle while the result is taken; the output register is refilled in the cycle it drains.
// The critical combinational path is the add, reciprocal multiply and eight-way channel search.
// Reset (synchronous, rst_n low): scan idle, channel 0, sums cleared, table reads 0xFFFF.
// Depends on adcs_pkg, adcs_in_if, adcs_out_if and the assertion macro header.
`include "adc_scan_averaging_sequencer_defines.svh"

module adc_scan_averaging_sequencer #(
  parameter int unsigned SAMPLES_TO_AVERAGE = adcs_pkg::DEF_SAMPLES_TO_AVERAGE,
  parameter int unsigned CHANNELS           = adcs_pkg::DEF_CHANNELS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  adcs_in_if.sink                         in_if,
  adcs_out_if.source                      out_if,
  input  logic                            cfg_we,
  input  logic [adcs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [adcs_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int unsigned SUM_W   = adcs_pkg::SUM_W;
  localparam int unsigned DIV_M_W = adcs_pkg::DIV_M_W;
  localparam int unsigned PROD_W  = SUM_W + DIV_M_W;

  // Exact truncating divide of a 16-bit sum by the sample count: multiply by
  // ceil(2^(16+l)/N) with l = clog2(N), then shift right by 16+l.
  localparam int unsigned DIV_SH = SUM_W + $clog2(SAMPLES_TO_AVERAGE);
  localparam logic [DIV_M_W-1:0] DIV_M = DIV_M_W'(
    ((64'd1 << DIV_SH) + 64'(SAMPLES_TO_AVERAGE) - 64'd1) / 64'(SAMPLES_TO_AVERAGE));

  localparam logic [adcs_pkg::COUNT_W-1:0] COUNT_END =
    adcs_pkg::COUNT_W'(SAMPLES_TO_AVERAGE);

  // Only mask bits of implemented channels take part in the scan.
  localparam logic [adcs_pkg::MASK_W-1:0] CH_MASK =
    adcs_pkg::MASK_W'((16'd1 << CHANNELS) - 16'd1);
  localparam logic [adcs_pkg::CH_W:0] CH_COUNT = (adcs_pkg::CH_W + 1)'(CHANNELS);

  // Configuration registers
  logic [adcs_pkg::MASK_W-1:0] mask_r;
  logic                        free_run_r;

  // Scan state
  logic [adcs_pkg::CH_W-1:0]    cur_ch_r, cur_ch_nxt;
  logic                         busy_r, busy_nxt;
  logic [SUM_W-1:0]             sum_r, sum_nxt;
  logic [adcs_pkg::COUNT_W-1:0] cnt_r, cnt_nxt;

  // Result table: a valid bit per entry, invalid entries read as no result
  logic [adcs_pkg::TABLE_DEPTH-1:0] tbl_vld_r;
  logic [adcs_pkg::SAMPLE_W-1:0]    tbl_val_r [adcs_pkg::TABLE_DEPTH];
  logic                             tbl_we;

  // Output register
  logic                          out_valid_r;
  logic                          start_r, start_nxt;
  logic                          avg_vld_r, avg_vld_nxt;
  logic [adcs_pkg::CH_W-1:0]     avg_ch_r, avg_ch_nxt;
  logic [adcs_pkg::SAMPLE_W-1:0] avg_val_r, avg_val_nxt;
  logic [adcs_pkg::RDATA_W-1:0]  rdata_r, rdata_nxt;

  logic                          in_fire;
  logic [adcs_pkg::MASK_W-1:0]   live;
  logic                          live_any;
  logic [adcs_pkg::CH_W:0]       cand;
  logic [adcs_pkg::CH_W-1:0]     next_ch;
  logic [SUM_W-1:0]              acc_sum;
  logic [adcs_pkg::COUNT_W-1:0]  acc_cnt;
  logic [PROD_W-1:0]             prod;
  logic [adcs_pkg::SAMPLE_W-1:0] quot;

  // Take a new item whenever the output register is empty or draining.
  assign in_if.ready = !out_valid_r || out_if.ready;
  assign in_fire     = in_if.valid && in_if.ready;

  // Next enabled channel after the current one, wrapping; it may be the
  // current channel itself. Walk from the far end so the nearest one wins.
  assign live     = mask_r & CH_MASK;
  assign live_any = |live;

  always_comb begin
    next_ch = cur_ch_r;
    cand    = '0;
    for (int k = CHANNELS; k >= 1; k--) begin
      cand = {1'b0, cur_ch_r} + (adcs_pkg::CH_W + 1)'(k);
      if (cand >= CH_COUNT) begin
        cand = cand - CH_COUNT;
      end
      if (live[cand[adcs_pkg::CH_W-1:0]]) begin
        next_ch = cand[adcs_pkg::CH_W-1:0];
      end
    end
  end

  // Accumulate and divide; the quotient is used only when the count completes.
  assign acc_sum = sum_r + SUM_W'(in_if.sample_value);
  assign acc_cnt = cnt_r + adcs_pkg::COUNT_W'(1);
  assign prod    = PROD_W'(acc_sum) * PROD_W'(DIV_M);
  assign quot    = adcs_pkg::SAMPLE_W'(prod >> DIV_SH);

  // Work for one item, from the held state to the next state and result.
  always_comb begin
    cur_ch_nxt  = cur_ch_r;
    busy_nxt    = busy_r;
    sum_nxt     = sum_r;
    cnt_nxt     = cnt_r;
    tbl_we      = 1'b0;
    start_nxt   = 1'b0;
    avg_vld_nxt = 1'b0;
    avg_ch_nxt  = '0;
    avg_val_nxt = '0;
    rdata_nxt   = '0;
    case (in_if.operation)
      adcs_pkg::OP_SAMPLE: begin
        // Drop samples that arrive with no conversion outstanding.
        if (busy_r) begin
          if (acc_cnt == COUNT_END) begin
            avg_vld_nxt = 1'b1;
            avg_ch_nxt  = cur_ch_r;
            avg_val_nxt = quot;
            tbl_we      = 1'b1;
            sum_nxt     = '0;
            cnt_nxt     = '0;
            busy_nxt    = 1'b0;
            if (free_run_r && live_any) begin
              cur_ch_nxt = next_ch;
              busy_nxt   = 1'b1;
              start_nxt  = 1'b1;
            end
          end else begin
            // Convert the same channel again.
            sum_nxt   = acc_sum;
            cnt_nxt   = acc_cnt;
            start_nxt = 1'b1;
          end
        end
      end
      adcs_pkg::OP_START: begin
        if (!busy_r && live_any) begin
          cur_ch_nxt = next_ch;
          busy_nxt   = 1'b1;
          start_nxt  = 1'b1;
        end
      end
      adcs_pkg::OP_READ: begin
        rdata_nxt = tbl_vld_r[in_if.read_channel]
                  ? adcs_pkg::RDATA_W'(tbl_val_r[in_if.read_channel])
                  : adcs_pkg::NO_RESULT;
      end
      default: begin
      end
    endcase
  end

  // Control state, configuration and table valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      free_run_r  <= 1'b0;
      cur_ch_r    <= '0;
      busy_r      <= 1'b0;
      sum_r       <= '0;
      cnt_r       <= '0;
      tbl_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          adcs_pkg::CFG_ENABLED_MASK: mask_r     <= cfg_wdata;
          adcs_pkg::CFG_FREE_RUN:     free_run_r <= cfg_wdata[0];
          default: begin
          end
        endcase
      end
      if (in_fire) begin
        cur_ch_r <= cur_ch_nxt;
        busy_r   <= busy_nxt;
        sum_r    <= sum_nxt;
        cnt_r    <= cnt_nxt;
        if (tbl_we) begin
          tbl_vld_r[avg_ch_nxt] <= 1'b1;
        end
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload: table entries and the output register hold without reset.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (tbl_we) begin
        tbl_val_r[avg_ch_nxt] <= avg_val_nxt;
      end
      start_r   <= start_nxt;
      avg_vld_r <= avg_vld_nxt;
      avg_ch_r  <= avg_ch_nxt;
      avg_val_r <= avg_val_nxt;
      rdata_r   <= rdata_nxt;
    end
  end

  // State only moves with an accepted item, so the current channel after the
  // held item is the live channel register.
  assign out_if.valid            = out_valid_r;
  assign out_if.start_conversion = start_r;
  assign out_if.conv_channel     = cur_ch_r;
  assign out_if.avg_valid        = avg_vld_r;
  assign out_if.avg_channel      = avg_ch_r;
  assign out_if.avg_value        = avg_val_r;
  assign out_if.read_data        = rdata_r;

  // A reported launch leaves a conversion outstanding.
  `ADCS_ASSERT_IMPLY(start_busy_a, clk, rst_n, out_valid_r && start_r, busy_r)
  // A completed average without a free-run launch leaves the scan idle.
  `ADCS_ASSERT_IMPLY(avg_idle_a, clk, rst_n, out_valid_r && avg_vld_r && !start_r, !busy_r)
  // Idle scan holds a cleared accumulator.
  `ADCS_ASSERT_IMPLY(idle_clear_a, clk, rst_n, !busy_r, (sum_r == '0) && (cnt_r == '0))
  // A start request while busy leaves the channel alone.
  `ADCS_ASSERT_NEXT(start_ignored_a, clk, rst_n,
    in_fire && (in_if.operation == adcs_pkg::OP_START) && busy_r, $stable(cur_ch_r))

endmodule
